/* design/bamc_pkg.sv */
// Package for the bank account modulus-11 check: field widths, digit weights,
// pipeline sizing and configuration register map.
// No dependencies.
package bamc_pkg;

  localparam int NUM_W  = 34;               // account number width
  localparam int NUM_IW = $clog2(NUM_W);    // bit index width
  localparam int RADIX  = 10;
  localparam int MAX_DIGITS = 10;

  // Binary-to-BCD conversion: input bits consumed per pipeline stage
  localparam int DD_STEPS  = 7;
  localparam int DD_STAGES = (NUM_W + DD_STEPS - 1) / DD_STEPS;

  // Weighted digit sum: at most 9 * (1+2+4+8+5+10+9+7+3+6) = 495
  localparam int SUM_W = 9;

  // Remainder by 11 through a reciprocal multiply: floor(s/11) == (s*373)>>12
  // holds for every s below 512.
  localparam int                MODULUS   = 11;
  localparam logic [SUM_W-1:0]  MOD_MUL   = 9'd373;
  localparam int                MOD_SHIFT = 12;
  localparam int                QUO_W     = 2 * SUM_W - MOD_SHIFT;

  localparam logic [3:0] WEIGHT [MAX_DIGITS] = '{
    4'd1, 4'd2, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 4'd7, 4'd3, 4'd6
  };

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_REPORT_INVALID = 1'b0;  // word index, paddr[2]

  // Largest number with the given count of decimal digits
  function automatic logic [NUM_W-1:0] num_limit(int digits);
    logic [NUM_W-1:0] lim;
    lim = NUM_W'(1);
    for (int i = 0; i < digits; i++) begin
      lim = lim * NUM_W'(RADIX);
    end
    return lim - NUM_W'(1);
  endfunction

endpackage

/* design/bamc_if.sv */
// Valid/ready channel interfaces for account numbers in and check results out.
// Depends on bamc_pkg.
interface bamc_in_if import bamc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] account_number;

  modport source (output valid, output account_number, input ready);
  modport sink   (input valid, input account_number, output ready);
endinterface

interface bamc_out_if import bamc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number_echo;
  logic             is_valid;

  modport source (output valid, output number_echo, output is_valid, input ready);
  modport sink   (input valid, input number_echo, input is_valid, output ready);
endinterface

/* design/bamc_cfg_regs.sv */
// APB-style configuration register holding report_invalid.
// Depends on bamc_pkg.
module bamc_cfg_regs import bamc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic              report_invalid
);

  logic report_invalid_r;
  logic report_invalid_nxt;
  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_REPORT_INVALID);

  always_comb begin
    report_invalid_nxt = report_invalid_r;
    if (wr_hit) begin
      report_invalid_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_invalid_r <= 1'b1;
    end else begin
      report_invalid_r <= report_invalid_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_REPORT_INVALID) begin
      prdata = CFG_DW'(report_invalid_r);
    end
  end

  assign report_invalid = report_invalid_r;

endmodule

/* design/bamc_dd_stage.sv */
// One stage of the pipelined binary-to-BCD converter (shift and add-3).
// Depends on bamc_pkg.
module bamc_dd_stage import bamc_pkg::*; #(
  parameter int DIGITS = 10,
  parameter int STG    = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NUM_W-1:0]    in_num,
  input  logic [4*DIGITS-1:0] in_bcd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NUM_W-1:0]    out_num,
  output logic [4*DIGITS-1:0] out_bcd
);

  localparam int BW        = 4 * DIGITS;
  localparam int FIRST_BIT = NUM_W - 1 - STG * DD_STEPS;

  logic          valid_r;
  logic          valid_nxt;
  logic [NUM_W-1:0] num_r;
  logic [BW-1:0] bcd_r;
  logic [BW-1:0] bcd_nxt;
  logic          load;
  int            bi;

  // Consume up to DD_STEPS number bits, most significant first
  always_comb begin
    bcd_nxt = in_bcd;
    bi      = 0;
    for (int j = 0; j < DD_STEPS; j++) begin
      bi = FIRST_BIT - j;
      if (bi >= 0) begin
        for (int d = 0; d < DIGITS; d++) begin
          if (bcd_nxt[4*d +: 4] >= 4'd5) begin
            bcd_nxt[4*d +: 4] = bcd_nxt[4*d +: 4] + 4'd3;
          end
        end
        bcd_nxt = {bcd_nxt[BW-2:0], in_num[bi[NUM_IW-1:0]]};
      end
    end
  end

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num_r <= in_num;
      bcd_r <= bcd_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_num   = num_r;
  assign out_bcd   = bcd_r;

endmodule

/* design/bamc_check.sv */
// Weighted digit sum, remainder by 11, range check and result register.
// Depends on bamc_pkg.
module bamc_check import bamc_pkg::*; #(
  parameter int               DIGITS = 10,
  parameter logic [NUM_W-1:0] LIMIT  = 34'd9999999999
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NUM_W-1:0]    in_num,
  input  logic [4*DIGITS-1:0] in_bcd,
  input  logic                report_invalid,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NUM_W-1:0]    out_num,
  output logic                out_ok
);

  // Sum stage
  logic             sv_r;
  logic             sv_nxt;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic             inrange_r;
  logic [NUM_W-1:0] snum_r;
  logic             s_ready;

  // Result stage
  logic               ov_r;
  logic               ov_nxt;
  logic [NUM_W-1:0]   onum_r;
  logic               ook_r;
  logic [2*SUM_W-1:0] prod;
  logic [QUO_W-1:0]   quo;
  logic [SUM_W-1:0]   quo_x11;
  logic               ok;
  logic               keep;
  logic               o_ready;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < DIGITS; i++) begin
      sum_nxt = sum_nxt + SUM_W'(in_bcd[4*i +: 4]) * SUM_W'(WEIGHT[i]);
    end
  end

  assign o_ready  = !ov_r || out_ready;
  assign s_ready  = !sv_r || o_ready;
  assign in_ready = s_ready;

  always_comb begin
    sv_nxt = sv_r;
    if (s_ready) begin
      sv_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s_ready) begin
      sum_r     <= sum_nxt;
      inrange_r <= (in_num <= LIMIT);
      snum_r    <= in_num;
    end
  end

  // Divisible by 11 when the sum equals 11 * floor(sum / 11)
  assign prod    = (2*SUM_W)'(sum_r) * (2*SUM_W)'(MOD_MUL);
  assign quo     = prod[MOD_SHIFT +: QUO_W];
  assign quo_x11 = SUM_W'(quo) * SUM_W'(MODULUS);
  assign ok      = inrange_r && (sum_r == quo_x11);
  assign keep    = ok || report_invalid;

  always_comb begin
    ov_nxt = ov_r;
    if (o_ready) begin
      ov_nxt = sv_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      sv_r <= sv_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r && o_ready) begin
      onum_r <= snum_r;
      ook_r  <= ok;
    end
  end

  assign out_valid = ov_r;
  assign out_num   = onum_r;
  assign out_ok    = ook_r;

  a_invalid_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ook_r |-> report_invalid)
    else $error("invalid number delivered while report_invalid is clear");

  a_range_forces_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (onum_r > LIMIT) |-> !ook_r)
    else $error("out-of-range number reported valid");

  a_zero_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (onum_r == '0) |-> ook_r)
    else $error("zero reported invalid");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !ov_r && !sv_r)
    else $error("pipeline holds a word after reset");

endmodule

/* design/bank_account_mod11_check_unit.sv */
// Bank account modulus-11 check. Each account number word accepted on in_ch is
// converted to decimal digits by a pipelined shift-and-add-3 converter (five
// stages of seven number bits each, six in the last), the digits, least significant
// first, are weighted 1,2,4,8,5,10,9,7,3,6 and summed, and the number is valid when
// that sum is a multiple of 11 and the number has no more than DIGITS digits. A
// result word is registered through the five converter stages, the sum stage and
// the result register, the first of them loaded at the accepting edge; one number
// is accepted every cycle, with backpressure propagating stage by stage. With
// report_invalid (register 0, byte address 0, reset 1) cleared, invalid numbers are
// dropped and produce no result word. Write the register only while the pipeline is
// empty.
// Depends on bamc_pkg, bamc_if, bamc_cfg_regs, bamc_dd_stage, bamc_check.
module bank_account_mod11_check_unit import bamc_pkg::*; #(
  parameter int DIGITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  bamc_in_if.sink           in_ch,
  bamc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int               BW    = 4 * DIGITS;
  localparam logic [NUM_W-1:0] LIMIT = num_limit(DIGITS);

  logic             report_invalid;

  // Converter chain: index 0 is the input side, DD_STAGES the check side
  logic             st_valid [DD_STAGES+1];
  logic             st_ready [DD_STAGES+1];
  logic [NUM_W-1:0] st_num   [DD_STAGES+1];
  logic [BW-1:0]    st_bcd   [DD_STAGES+1];

  bamc_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .report_invalid (report_invalid)
  );

  // Feed the converter straight from the channel; BCD accumulator starts empty
  assign st_valid[0] = in_ch.valid;
  assign st_num[0]   = in_ch.account_number;
  assign st_bcd[0]   = '0;
  assign in_ch.ready = st_ready[0];

  for (genvar s = 0; s < DD_STAGES; s++) begin : g_dd
    bamc_dd_stage #(
      .DIGITS (DIGITS),
      .STG    (s)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[s]),
      .in_ready  (st_ready[s]),
      .in_num    (st_num[s]),
      .in_bcd    (st_bcd[s]),
      .out_valid (st_valid[s+1]),
      .out_ready (st_ready[s+1]),
      .out_num   (st_num[s+1]),
      .out_bcd   (st_bcd[s+1])
    );
  end

  // Weigh the digits, reduce by 11, hold the result until taken
  bamc_check #(
    .DIGITS (DIGITS),
    .LIMIT  (LIMIT)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (st_valid[DD_STAGES]),
    .in_ready       (st_ready[DD_STAGES]),
    .in_num         (st_num[DD_STAGES]),
    .in_bcd         (st_bcd[DD_STAGES]),
    .report_invalid (report_invalid),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_num        (out_ch.number_echo),
    .out_ok         (out_ch.is_valid)
  );

endmodule
